// ===== design/e2c_pkg.sv =====
package e2c_pkg;

    // Reciprocals for division by a constant. For every 32-bit x,
    // x / 60 = (x * Recip60) >> 37 and x / 24 = (x * Recip24) >> 36.
    localparam logic [31:0] Recip60 = 32'h88888889;
    localparam logic [31:0] Recip24 = 32'hAAAAAAAB;

    localparam logic [11:0] FirstYear   = 12'd1970;
    localparam logic [6:0]  FirstMod100 = 7'd70;
    localparam logic [8:0]  FirstMod400 = 9'd370;
    localparam logic [8:0]  DaysCommon  = 9'd365;
    localparam logic [7:0]  YearBias    = 8'(2000 % 256);

    localparam logic [3:0] MonJan = 4'd0;
    localparam logic [3:0] MonFeb = 4'd1;
    localparam logic [3:0] MonApr = 4'd3;
    localparam logic [3:0] MonJun = 4'd5;
    localparam logic [3:0] MonSep = 4'd8;
    localparam logic [3:0] MonNov = 4'd10;
    localparam logic [3:0] MonDec = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEC,
        S_MIN,
        S_HOUR,
        S_DAYS,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_sec;
        logic mul_min;
        logic mul_hour;
        logic end_hour;
        logic year_step;
        logic month_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_stat;

    // Length of a month, index 0 is January.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        unique case (mon)
            MonFeb:                         len = leap ? 5'd29 : 5'd28;
            MonApr, MonJun, MonSep, MonNov: len = 5'd30;
            default:                        len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/e2c_ctrl.sv =====
// Sequencer: three reciprocal divisions, the hour and day split, then the
// year walk, then the month walk.
module e2c_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  e2c_pkg::t_dp_stat  i_stat,
    output e2c_pkg::t_dp_cmd   o_cmd,
    output logic               busy,
    output logic               o_valid
);

    e2c_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= e2c_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            e2c_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = e2c_pkg::S_SEC;
                end
            end
            e2c_pkg::S_SEC: begin
                o_cmd.mul_sec = 1'b1;
                n_state       = e2c_pkg::S_MIN;
            end
            e2c_pkg::S_MIN: begin
                o_cmd.mul_min = 1'b1;
                n_state       = e2c_pkg::S_HOUR;
            end
            e2c_pkg::S_HOUR: begin
                o_cmd.mul_hour = 1'b1;
                n_state        = e2c_pkg::S_DAYS;
            end
            e2c_pkg::S_DAYS: begin
                o_cmd.end_hour = 1'b1;
                n_state        = e2c_pkg::S_YEAR;
            end
            e2c_pkg::S_YEAR: begin
                if (i_stat.year_done) begin
                    n_state = e2c_pkg::S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            e2c_pkg::S_MONTH: begin
                if (i_stat.month_done) begin
                    n_state = e2c_pkg::S_DONE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            e2c_pkg::S_DONE: begin
                n_state = e2c_pkg::S_IDLE;
            end
            default: begin
                n_state = e2c_pkg::S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != e2c_pkg::S_IDLE);
    assign o_valid = (r_state == e2c_pkg::S_DONE);

endmodule

// ===== design/e2c_dp.sv =====
// Datapath: a shared reciprocal multiplier for the divisions by 60 and 24,
// and the year and month subtractors with their leap-year counters.
module e2c_dp (
    input  logic              i_clk,
    input  e2c_pkg::t_dp_cmd  i_cmd,
    input  logic [31:0]       i_epoch_seconds,
    output e2c_pkg::t_dp_stat o_stat,
    output logic [5:0]        o_second_of_minute,
    output logic [5:0]        o_minute_of_hour,
    output logic [4:0]        o_hour_of_day,
    output logic [4:0]        o_day_of_month,
    output logic [3:0]        o_month_of_year,
    output logic [11:0]       o_full_year,
    output logic [7:0]        o_year_after_2000
);

    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [15:0] r_days;
    logic [11:0] r_yr;
    logic [6:0]  r_mod100;
    logic [8:0]  r_mod400;
    logic [3:0]  r_mon;

    logic [31:0] recip;
    logic [63:0] prod;
    logic [31:0] quo_next;
    logic [31:0] quo_x60;
    logic [31:0] quo_x24;
    logic [31:0] rem60;
    logic [31:0] rem24;
    logic        leap;
    logic [8:0]  yr_len;
    logic [4:0]  mon_len;

    // The quotient register feeds the multiplier; the previous dividend and
    // the quotient give the remainder in parallel with the next product.
    assign recip    = i_cmd.mul_hour ? e2c_pkg::Recip24 : e2c_pkg::Recip60;
    assign prod     = {32'd0, r_quo} * {32'd0, recip};
    assign quo_next = i_cmd.mul_hour ? {4'd0, prod[63:36]} : {5'd0, prod[63:37]};
    assign quo_x60  = {r_quo[25:0], 6'd0} - {r_quo[29:0], 2'd0};
    assign quo_x24  = {r_quo[27:0], 4'd0} + {r_quo[28:0], 3'd0};
    assign rem60    = r_div - quo_x60;
    assign rem24    = r_div - quo_x24;

    assign leap    = ((r_yr[1:0] == 2'd0) && (r_mod100 != '0)) || (r_mod400 == '0);
    assign yr_len  = e2c_pkg::DaysCommon + {8'd0, leap};
    assign mon_len = e2c_pkg::month_len(r_mon, leap);

    assign o_stat.year_done  = (r_days < {7'd0, yr_len});
    assign o_stat.month_done = (r_mon == e2c_pkg::MonDec) || (r_days < {11'd0, mon_len});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo    <= i_epoch_seconds;
            r_yr     <= e2c_pkg::FirstYear;
            r_mod100 <= e2c_pkg::FirstMod100;
            r_mod400 <= e2c_pkg::FirstMod400;
            r_mon    <= e2c_pkg::MonJan;
        end else if (i_cmd.mul_sec) begin
            r_div <= r_quo;
            r_quo <= quo_next;
        end else if (i_cmd.mul_min) begin
            r_sec <= rem60[5:0];
            r_div <= r_quo;
            r_quo <= quo_next;
        end else if (i_cmd.mul_hour) begin
            r_min <= rem60[5:0];
            r_div <= r_quo;
            r_quo <= quo_next;
        end else if (i_cmd.end_hour) begin
            r_hour <= rem24[4:0];
            r_days <= r_quo[15:0];
        end else if (i_cmd.year_step) begin
            r_days   <= r_days - {7'd0, yr_len};
            r_yr     <= r_yr + 12'd1;
            r_mod100 <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
        end else if (i_cmd.month_step) begin
            r_days <= r_days - {11'd0, mon_len};
            r_mon  <= r_mon + 4'd1;
        end
    end

    assign o_second_of_minute = r_sec;
    assign o_minute_of_hour   = r_min;
    assign o_hour_of_day      = r_hour;
    assign o_day_of_month     = r_days[4:0] + 5'd1;
    assign o_month_of_year    = r_mon + 4'd1;
    assign o_full_year        = r_yr;
    assign o_year_after_2000  = r_yr[7:0] - e2c_pkg::YearBias;

endmodule

// ===== design/epoch_to_calendar_time_core.sv =====
// Channel   Direction  Transfer condition      Payload
// input     in         start high, busy low    i_epoch_seconds
// result    out        o_valid high            o_second_of_minute .. o_year_after_2000
//
// One conversion is worked at a time; busy stays high from the accepting edge
// until the cycle after the result strobe. The steps are three multiplies on
// the shared reciprocal divider, the hour and day split, a year walk at one
// year per cycle over Y, the number of whole years after 1970 (0..136), and
// a month walk at one month per cycle over M, the number of whole months
// into the year (0..11). The conversion is longest for a date in December 2105.
// Reset is synchronous and active low and returns the controller to idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module epoch_to_calendar_time_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_epoch_seconds,
    output logic        busy,
    output logic        o_valid,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_of_year,
    output logic [11:0] o_full_year,
    output logic [7:0]  o_year_after_2000
);

    // Command and status bundles between the sequencer and the datapath.
    e2c_pkg::t_dp_cmd  cmd;
    e2c_pkg::t_dp_stat stat;

    // The controller walks the divisions, the year search and the month
    // search, and raises the strobe once the datapath registers are final.
    e2c_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // The datapath holds the dividend, the remaining day count, the year with
    // its modulo-100 and modulo-400 counters, and the finished fields.
    e2c_dp u_dp (
        .i_clk              (i_clk),
        .i_cmd              (cmd),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_stat             (stat),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_of_year    (o_month_of_year),
        .o_full_year        (o_full_year),
        .o_year_after_2000  (o_year_after_2000)
    );

endmodule

// ===== design/e2c_checker.sv =====
module e2c_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [5:0]  o_second_of_minute,
    input logic [5:0]  o_minute_of_hour,
    input logic [4:0]  o_hour_of_day,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month_of_year
);

    // A transfer starts a conversion.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an input transfer");

    // The strobe only comes during a conversion and ends it.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a conversion");

    a_valid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("conversion did not end after its result");

    // Fields of a delivered result lie in their calendar ranges.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_second_of_minute < 6'd60) && (o_minute_of_hour < 6'd60) &&
                     (o_hour_of_day < 5'd24) && (o_day_of_month != 5'd0) &&
                     (o_month_of_year != 4'd0) && (o_month_of_year < 4'd13)))
        else $error("result field out of range");

endmodule

bind epoch_to_calendar_time_core e2c_checker u_e2c_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_second_of_minute (o_second_of_minute),
    .o_minute_of_hour   (o_minute_of_hour),
    .o_hour_of_day      (o_hour_of_day),
    .o_day_of_month     (o_day_of_month),
    .o_month_of_year    (o_month_of_year)
);

// ===== dv/tb.sv =====
module tb;

    // A date and time of day, packed at the widths of the result ports.
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
        logic [7:0]  yy;
    } cal_t;

    // One row of the directed table. Rows with has_want set carry a date
    // that can be checked by eye. All other rows go through the converter
    // below.
    typedef struct packed {
        logic [31:0] epoch;
        logic        has_want;
        cal_t        want;
    } stim_row_t;

    localparam int NumDirected = 20;
    localparam int NumRandom   = 1800;
    // The tail after the last result leaves room for any stray
    // strobe to show up.
    localparam int TailCycles  = 300;

    // Common-year month lengths. Index 0 is January, so December comes first
    // in the concatenation.
    localparam logic [11:0][4:0] MonthDays = {
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
        5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic [31:0] i_epoch_seconds;
    logic        busy;
    logic        o_valid;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_of_year;
    logic [11:0] o_full_year;
    logic [7:0]  o_year_after_2000;

    // Dates that are still owed by the block, oldest first.
    cal_t pending_dates[$];
    int   mismatches = 0;

    epoch_to_calendar_time_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_epoch_seconds    (i_epoch_seconds),
        .busy               (busy),
        .o_valid            (o_valid),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_of_year    (o_month_of_year),
        .o_full_year        (o_full_year),
        .o_year_after_2000  (o_year_after_2000)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The run is bounded by this watchdog. The slowest legal run is 1820 transfers,
    // each taking the longest busy window plus the longest idle gap that the
    // stimulus draws, and the watchdog limit lies above that sum.
    initial begin
        #80_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Converts a seconds count into the date the block must return. The time
    // of day comes from plain division. Whole years are then stripped off the
    // day count starting at 1970, and whole months off the rest.
    function automatic cal_t epoch_to_date(input logic [31:0] t);
        cal_t        r;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        r.sec    = 6'(t % 60);
        r.minute = 6'((t / 60) % 60);
        r.hour   = 5'((t / 3600) % 24);
        days     = t / 86400;
        yr       = 1970;
        forever begin
            len = leap_year(yr) ? 366 : 365;
            if (days < len) break;
            days -= len;
            yr++;
        end
        mon = 0;
        // Fewer than 366 days are left, so December takes whatever remains.
        while (mon < 11) begin
            len = MonthDays[mon];
            if (mon == 1 && leap_year(yr)) len = 29;
            if (days < len) break;
            days -= len;
            mon++;
        end
        r.mday  = 5'(days + 1);
        r.month = 4'(mon + 1);
        r.year  = 12'(yr);
        // This wraps below 2000 the same way an 8-bit unsigned cast does.
        r.yy    = 8'(yr - 2000);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Result side. A strobe lasts exactly one cycle, and the block cannot be
    // stalled. Each strobe is taken at the edge that closes its cycle and is
    // matched against the oldest owed date.
    always @(posedge i_clk) begin
        cal_t want;
        if (i_rst_n && o_valid) begin
            if (pending_dates.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %0d-%0d-%0d %0d:%0d:%0d",
                                          o_full_year, o_month_of_year, o_day_of_month,
                                          o_hour_of_day, o_minute_of_hour,
                                          o_second_of_minute));
            end else begin
                want = pending_dates.pop_front();
                check_field("second_of_minute", o_second_of_minute, want.sec);
                check_field("minute_of_hour",   o_minute_of_hour,   want.minute);
                check_field("hour_of_day",      o_hour_of_day,      want.hour);
                check_field("day_of_month",     o_day_of_month,     want.mday);
                check_field("month_of_year",    o_month_of_year,    want.month);
                check_field("full_year",        o_full_year,        want.year);
                check_field("year_after_2000",  o_year_after_2000,  want.yy);
            end
        end
    end

    // Directed rows cover the field extremes, the first and last representable
    // seconds, the wrap of the two-digit year below 2000, a 400-year leap day,
    // the skipped leap day of 2100, and day, year and century edges.
    stim_row_t directed_rows[NumDirected] = '{
        '{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd1,  12'd1970, 8'd226}},
        '{32'd4294967295, 1'b1, '{6'd15, 6'd28, 5'd6,  5'd7,  4'd2,  12'd2106, 8'd106}},
        '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 5'd1,  4'd1,  12'd1970, 8'd226}},
        '{32'd86400,      1'b1, '{6'd0,  6'd0,  5'd0,  5'd2,  4'd1,  12'd1970, 8'd226}},
        '{32'd946684799,  1'b1, '{6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 12'd1999, 8'd255}},
        '{32'd946684800,  1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd1,  12'd2000, 8'd0}},
        '{32'd951782400,  1'b1, '{6'd0,  6'd0,  5'd0,  5'd29, 4'd2,  12'd2000, 8'd0}},
        '{32'd4102444800, 1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd1,  12'd2100, 8'd100}},
        '{32'd4107542400, 1'b1, '{6'd0,  6'd0,  5'd0,  5'd1,  4'd3,  12'd2100, 8'd100}},
        '{32'd4107542399, 1'b0, '0},
        '{32'd4102444799, 1'b0, '0},
        '{32'd31535999,   1'b0, '0},
        '{32'd31536000,   1'b0, '0},
        '{32'd68255999,   1'b0, '0},
        '{32'd951868800,  1'b0, '0},
        '{32'd4294967294, 1'b0, '0},
        '{32'h7FFFFFFF,   1'b0, '0},
        '{32'h80000000,   1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'h55555555,   1'b0, '0}
    };

    // Request side. Transfers come in bursts of random length. Inside a burst,
    // start stays high and the next seconds count is presented at the edge
    // that accepted the previous one. Between bursts, start drops for a random
    // number of cycles, or stays high when the gap drawn is zero. Gaps are
    // sometimes long enough to span a whole conversion, so the next request
    // can arrive at any point of the busy window.
    initial begin
        int          n;
        int          burst_left;
        int          gap;
        int          sel;
        int unsigned yr;
        int unsigned mon;
        int unsigned y;
        int unsigned m;
        longint      secs;
        logic [31:0] epoch;
        cal_t        want;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_epoch_seconds = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = 0;
        for (n = 0; n < NumDirected + NumRandom; n++) begin
            if (burst_left == 0) begin
                sel = $urandom_range(0, 9);
                if (sel < 3)      gap = 0;
                else if (sel < 9) gap = $urandom_range(1, 40);
                else              gap = $urandom_range(41, 240);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 12);
            end

            if (n < NumDirected) begin
                epoch = directed_rows[n].epoch;
                want  = directed_rows[n].has_want ? directed_rows[n].want
                                                  : epoch_to_date(epoch);
            end else begin
                sel = $urandom_range(0, 9);
                if (sel <= 5) begin
                    epoch = $urandom;
                end else if (sel == 6) begin
                    // Around midnight, including the wrap below zero.
                    secs  = longint'($urandom_range(0, 49710)) * 86400
                            + $urandom_range(0, 2) - 1;
                    epoch = 32'(secs);
                end else if (sel == 7) begin
                    // The first few years, where the two-digit year wraps.
                    epoch = $urandom_range(0, 94867200);
                end else begin
                    // Around the first of a random month in a random year.
                    yr   = $urandom_range(1970, 2106);
                    mon  = $urandom_range(0, 11);
                    secs = 0;
                    for (y = 1970; y < yr; y++) secs += leap_year(y) ? 366 : 365;
                    for (m = 0; m < mon; m++)
                        secs += MonthDays[m] + ((m == 1 && leap_year(yr)) ? 1 : 0);
                    secs = secs * 86400 + $urandom_range(0, 2) - 1;
                    if (secs < 0 || secs > 64'hFFFFFFFF) epoch = $urandom;
                    else                                 epoch = 32'(secs);
                end
                want = epoch_to_date(epoch);
            end

            start           <= 1'b1;
            i_epoch_seconds <= epoch;
            // Busy is sampled as it stood before the edge. An edge with busy
            // low is the one that accepts the transfer.
            do @(posedge i_clk); while (busy);
            pending_dates.push_back(want);
            burst_left--;
        end
        start <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== epoch_to_calendar_time_core.f =====
design/e2c_pkg.sv
design/e2c_ctrl.sv
design/e2c_dp.sv
design/epoch_to_calendar_time_core.sv
design/e2c_checker.sv
dv/tb.sv
